### rtl/maf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the moving average filter.
package maf_pkg;

    localparam int MAX_WINDOW_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 6;
    localparam int WINDOW_RESET    = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/moving_average_filter.sv
`timescale 1ns / 1ps
// Moving average filter: running sum over a ring of samples, serial divide by fill count.
// The result word is registered after the UPDATE, DIVIDE and FINISH states, and FINISH
// waits while the last output word is still held; one word in flight at a time, so
// a new word is taken only once the last result is loaded; the divider gives one quotient bit a cycle.
// Reset clears control, count, position and sum; the ring itself is not swept,
// entries past the fill count are treated as zero until rewritten.
module moving_average_filter #(
    parameter int MAX_WINDOW  = maf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            window_size_wr_en,
    input  logic [maf_pkg::CFG_BITS-1:0]    window_size,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SAMPLE_BITS-1:0]   sample_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [SAMPLE_BITS-1:0]   average_value,
    output logic                            window_full
);

    maf_pkg::ctrl_cmd_t  cmd;
    maf_pkg::dp_status_t status;

    maf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    maf_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .window_size_wr_en (window_size_wr_en),
        .window_size       (window_size),
        .sample_value      (sample_value),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .average_value     (average_value),
        .window_full       (window_full),
        .cmd               (cmd),
        .status            (status)
    );

endmodule

### rtl/maf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module maf_ram #(
    parameter int WIDTH = maf_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH = maf_pkg::MAX_WINDOW_DEF,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [ADDR_BITS-1:0]   wr_addr,
    input  logic [WIDTH-1:0]       wr_data,
    input  logic [ADDR_BITS-1:0]   rd_addr,
    output logic [WIDTH-1:0]       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/maf_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the moving average filter.
module maf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  maf_pkg::dp_status_t   status,
    output maf_pkg::ctrl_cmd_t    cmd
);

    maf_pkg::state_t state_reg;
    maf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= maf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            maf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = maf_pkg::ST_UPDATE;
                end
            end
            maf_pkg::ST_UPDATE:
            begin
                state_next = maf_pkg::ST_DIVIDE;
            end
            maf_pkg::ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = maf_pkg::ST_FINISH;
                end
            end
            maf_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = maf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = maf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            maf_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            maf_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            maf_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            maf_pkg::ST_FINISH:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/maf_dp.sv
`timescale 1ns / 1ps
// Datapath: sample ring, running total, fill count, serial divider, output word.
module maf_dp #(
    parameter int MAX_WINDOW  = maf_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            window_size_wr_en,
    input  logic [maf_pkg::CFG_BITS-1:0]    window_size,
    input  logic signed [SAMPLE_BITS-1:0]   sample_value,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic signed [SAMPLE_BITS-1:0]   average_value,
    output logic                            window_full,
    input  maf_pkg::ctrl_cmd_t              cmd,
    output maf_pkg::dp_status_t             status
);

    localparam int POS_BITS   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_BITS   = $clog2(MAX_WINDOW + 1);
    localparam int TOTAL_BITS = SAMPLE_BITS + POS_BITS;
    localparam int STEP_BITS  = $clog2(TOTAL_BITS);
    localparam int WIN_RESET  = (maf_pkg::WINDOW_RESET > MAX_WINDOW) ?
                                MAX_WINDOW : maf_pkg::WINDOW_RESET;

    logic [CNT_BITS-1:0]           window_reg, window_next;
    logic [POS_BITS-1:0]           pos_reg, pos_next;
    logic [CNT_BITS-1:0]           held_reg, held_next;
    logic signed [TOTAL_BITS-1:0]  total_reg, total_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          neg_reg;
    logic                          full_pend_reg;
    logic [TOTAL_BITS-1:0]         quo_reg, quo_next;
    logic [CNT_BITS-1:0]           rem_reg, rem_next;
    logic [CNT_BITS-1:0]           div_reg;
    logic [STEP_BITS-1:0]          step_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] avg_reg;
    logic                          full_reg;

    logic [31:0]                   cfg_ext;
    logic [CNT_BITS-1:0]           window_clamped;
    logic [CNT_BITS-1:0]           pos_inc;
    logic                          was_full;
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic signed [TOTAL_BITS-1:0]  leaving;
    logic [TOTAL_BITS-1:0]         total_mag;
    logic [CNT_BITS:0]             shifted;
    logic [CNT_BITS:0]             trial;
    logic [SAMPLE_BITS-1:0]        quo_low;

    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (cmd.update),
        .wr_addr (pos_reg),
        .wr_data (sample_reg),
        .rd_addr (pos_reg),
        .rd_data (old_sample)
    );

    // window clamp to 1..MAX_WINDOW
    always_comb
    begin
        cfg_ext        = 32'(window_size);
        window_clamped = (cfg_ext == 32'd0) ? CNT_BITS'(1) :
                         (cfg_ext > 32'(MAX_WINDOW)) ? CNT_BITS'(MAX_WINDOW) :
                         CNT_BITS'(cfg_ext);
    end

    // entries beyond the fill count were never written since restart: read as zero
    always_comb
    begin
        was_full   = (held_reg == window_reg);
        leaving    = was_full ? TOTAL_BITS'(old_sample) : '0;
        total_next = total_reg - leaving + TOTAL_BITS'(sample_reg);
        pos_inc    = CNT_BITS'(pos_reg) + CNT_BITS'(1);
        pos_next   = (pos_inc == window_reg) ? '0 : POS_BITS'(pos_inc);
        held_next  = (held_reg < window_reg) ? held_reg + CNT_BITS'(1) : held_reg;
        total_mag  = total_next[TOTAL_BITS-1] ? TOTAL_BITS'(-total_next) :
                     TOTAL_BITS'(total_next);
        window_next = window_clamped;
    end

    // restoring divide, one quotient bit per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[TOTAL_BITS-1]};
        trial   = shifted - {1'b0, div_reg};
        if (!trial[CNT_BITS])
        begin
            rem_next = trial[CNT_BITS-1:0];
            quo_next = {quo_reg[TOTAL_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[CNT_BITS-1:0];
            quo_next = {quo_reg[TOTAL_BITS-2:0], 1'b0};
        end
        quo_low = quo_reg[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= CNT_BITS'(WIN_RESET);
            pos_reg       <= '0;
            held_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (window_size_wr_en)
            begin
                window_reg <= window_next;
                pos_reg    <= '0;
                held_reg   <= '0;
                total_reg  <= '0;
            end
            else if (cmd.update)
            begin
                pos_reg   <= pos_next;
                held_reg  <= held_next;
                total_reg <= total_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample_value;
        end
        if (cmd.update)
        begin
            neg_reg       <= total_next[TOTAL_BITS-1];
            full_pend_reg <= (held_next == window_reg);
            quo_reg       <= total_mag;
            rem_reg       <= '0;
            div_reg       <= held_next;
            step_reg      <= STEP_BITS'(TOTAL_BITS - 1);
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg - STEP_BITS'(1);
        end
        if (cmd.load_out)
        begin
            avg_reg  <= neg_reg ? -quo_low : quo_low;
            full_reg <= full_pend_reg;
        end
    end

    assign status.div_last = (step_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign average_value = avg_reg;
    assign window_full   = full_reg;

endmodule

### rtl/maf_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the moving average filter, bound to the top level.
module maf_chk #(
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] average_value,
    input logic                          window_full
);

    // a waiting output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average_value) && $stable(window_full))
        else $error("output word changed while stalled");

    // one word in flight: no new word straight after an accepted one
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input taken while busy");

    // a result only appears at the end of a busy spell
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a word in flight");

endmodule

bind moving_average_filter maf_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_maf_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .average_value (average_value),
    .window_full   (window_full)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for moving_average_filter: directed table then random windowed streams.
module tb_top;

    localparam int SBITS    = maf_pkg::SAMPLE_BITS_DEF;
    localparam int RING     = maf_pkg::MAX_WINDOW_DEF;
    localparam int N_ROWS   = 24;
    localparam int N_RANDOM = 1700;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WINDOW
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [SBITS-1:0]  value;
        logic              known;
        logic [SBITS-1:0]  avg;
        logic              full;
    } row_t;

    typedef struct packed {
        logic signed [SBITS-1:0] avg;
        logic                    full;
    } average_word_t;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        window_size_wr_en = 1'b0;
    logic [maf_pkg::CFG_BITS-1:0] window_size = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic signed [SBITS-1:0]     sample_value = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic signed [SBITS-1:0]     average_value;
    logic                        window_full;

    // expectation typed into the table, carried alongside the sample word
    logic                        pinned = 1'b0;
    logic signed [SBITS-1:0]     pinned_avg = '0;
    logic                        pinned_full = 1'b0;

    logic signed [SBITS-1:0]     ring [RING];
    int                          ring_pos;
    int                          held;
    int                          window_len;
    int                          running_sum;

    average_word_t               averages_due [$];
    int                          mismatch_count = 0;
    int                          averages_seen = 0;
    int                          samples_taken = 0;
    int                          windows_loaded = 0;
    int                          burst_left = 0;

    row_t                        directed [N_ROWS];

    moving_average_filter dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .window_size_wr_en (window_size_wr_en),
        .window_size       (window_size),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .sample_value      (sample_value),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .average_value     (average_value),
        .window_full       (window_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("moving_average_filter: mismatch");
        $finish;
    end

    function automatic void restart_window(input int len);
        window_len  = len;
        ring_pos    = 0;
        held        = 0;
        running_sum = 0;
        for (int i = 0; i < RING; i++)
            ring[i] = '0;
    endfunction

    function automatic void apply_window_write(input logic [maf_pkg::CFG_BITS-1:0] w);
        int len;
        len = int'(w);
        if (len == 0)
            len = 1;
        if (len > RING)
            len = RING;
        restart_window(len);
    endfunction

    function automatic average_word_t advance_window(input logic signed [SBITS-1:0] s);
        average_word_t r;
        int            p;
        int            quotient;
        p = ring_pos;
        if (p >= window_len)
            p = 0;
        running_sum = running_sum - int'(ring[p]) + int'(s);
        ring[p] = s;
        p++;
        if (p >= window_len)
            p = 0;
        ring_pos = p;
        if (held < window_len)
            held++;
        quotient = running_sum / held;
        r.avg  = quotient[SBITS-1:0];
        r.full = (held == window_len);
        return r;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        average_word_t predicted;
        average_word_t due;
        if (!rst_n)
        begin
            restart_window(maf_pkg::WINDOW_RESET);
            averages_due.delete();
        end
        else
        begin
            if (window_size_wr_en)
                apply_window_write(window_size);
            if (in_valid && in_ready)
            begin
                predicted = advance_window(sample_value);
                if (pinned)
                begin
                    predicted.avg  = pinned_avg;
                    predicted.full = pinned_full;
                end
                averages_due.push_back(predicted);
                samples_taken++;
            end
            if (out_valid && out_ready)
            begin
                averages_seen++;
                if (averages_due.size() == 0)
                begin
                    $error("average word with nothing outstanding: average_value %0d",
                           average_value);
                    mismatch_count++;
                end
                else
                begin
                    due = averages_due.pop_front();
                    if (average_value !== due.avg)
                    begin
                        $error("average_value: expected %0d, got %0d", due.avg, average_value);
                        mismatch_count++;
                    end
                    if (window_full !== due.full)
                    begin
                        $error("window_full: expected %0d, got %0d", due.full, window_full);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // receiver: long ready stretches broken by stalls of varied length
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 80)) @(posedge clk);
            if ($urandom_range(0, 3) != 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    task automatic offer_sample(input logic signed [SBITS-1:0] s, input logic pin,
                                input logic signed [SBITS-1:0] pa, input logic pf);
        int gap;
        in_valid     <= 1'b1;
        sample_value <= s;
        pinned       <= pin;
        pinned_avg   <= pa;
        pinned_full  <= pf;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic settle(input int pause);
        in_valid <= 1'b0;
        @(posedge clk);
        while (averages_due.size() != 0)
            @(posedge clk);
        repeat (pause) @(posedge clk);
    endtask

    task automatic load_window(input logic [maf_pkg::CFG_BITS-1:0] w);
        settle(4);
        window_size_wr_en <= 1'b1;
        window_size       <= w;
        @(posedge clk);
        window_size_wr_en <= 1'b0;
        windows_loaded++;
    endtask

    function automatic logic [SBITS-1:0] draw_sample(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 1 && r < 80)
            return 16'h7fff - 16'($urandom_range(0, 3));
        if (mode == 2 && r < 80)
            return 16'h8000 + 16'($urandom_range(0, 3));
        if (r < 10)
        begin
            case ($urandom_range(0, 3))
                0: return 16'h7fff;
                1: return 16'h8000;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        if (r < 30)
            return 16'($signed($urandom_range(0, 64)) - 32);
        return 16'($urandom);
    endfunction

    initial
    begin : stimulus
        int sent;
        int phase;
        int mode;
        int count;
        logic [maf_pkg::CFG_BITS-1:0] w;

        directed = '{
            '{ROW_SAMPLE, 16'h7fff, 1'b1, 16'h7fff, 1'b0},
            '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'hffff, 1'b0, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'h0001, 1'b0, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'h5555, 1'b0, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'haaaa, 1'b0, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'h0064, 1'b0, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'hff9c, 1'b0, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'h0007, 1'b0, 16'h0000, 1'b0},
            '{ROW_WINDOW, 16'h0001, 1'b0, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000, 1'b1},
            '{ROW_SAMPLE, 16'h7fff, 1'b1, 16'h7fff, 1'b1},
            // zero is taken as a window of one
            '{ROW_WINDOW, 16'h0000, 1'b0, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'hfffb, 1'b1, 16'hfffb, 1'b1},
            // saturates to the full ring; -7 / 2 truncates to -3
            '{ROW_WINDOW, 16'h003f, 1'b0, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'hfff9, 1'b1, 16'hfff9, 1'b0},
            '{ROW_SAMPLE, 16'h0000, 1'b1, 16'hfffd, 1'b0},
            // same size again must still restart
            '{ROW_WINDOW, 16'h0020, 1'b0, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'h0064, 1'b1, 16'h0064, 1'b0},
            '{ROW_WINDOW, 16'h0002, 1'b0, 16'h0000, 1'b0},
            '{ROW_SAMPLE, 16'h0003, 1'b1, 16'h0003, 1'b0},
            '{ROW_SAMPLE, 16'h0004, 1'b1, 16'h0003, 1'b1},
            '{ROW_SAMPLE, 16'h8000, 1'b1, 16'hc002, 1'b1},
            '{ROW_SAMPLE, 16'h7fff, 1'b0, 16'h0000, 1'b0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_WINDOW)
                load_window(directed[i].value[maf_pkg::CFG_BITS-1:0]);
            else
                offer_sample(directed[i].value, directed[i].known,
                             directed[i].avg, directed[i].full);
        end

        sent  = 0;
        phase = 0;
        while (sent < N_RANDOM)
        begin
            case (phase)
                0: w = 6'd1;
                1: w = 6'd32;
                2: w = 6'd0;
                3: w = 6'd63;
                4: w = 6'd2;
                default: w = maf_pkg::CFG_BITS'($urandom_range(0, 63));
            endcase
            // pin the total near both rails on the wide windows
            mode  = (phase == 1) ? 1 : (phase == 3) ? 2 : $urandom_range(0, 3);
            count = $urandom_range(40, 160);
            load_window(w);
            for (int k = 0; k < count; k++)
                offer_sample(draw_sample(mode), 1'b0, '0, 1'b0);
            sent += count;
            phase++;
        end

        settle(30);
        $display("%0d samples accepted across %0d window sizes loaded after reset",
                 samples_taken, windows_loaded);
        $display("%0d average words compared, %0d field mismatches",
                 averages_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("moving_average_filter: match");
        else
            $display("moving_average_filter: mismatch");
        $finish;
    end

endmodule

### moving_average_filter.f
rtl/maf_pkg.sv
rtl/maf_ram.sv
rtl/maf_ctrl.sv
rtl/maf_dp.sv
rtl/moving_average_filter.sv
rtl/maf_chk.sv
tb/sv/tb_top.sv
